### src/grd_pkg.sv
// Shared types and constants for the gauge record demultiplexer.
package grd_pkg;

    localparam int WORD_W    = 32;
    localparam int IDX_W     = 8;
    localparam int POS_W     = 16;
    localparam int COUNT_W   = 9;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int KIND_W    = 2;
    localparam int CLASS_W   = 2;
    localparam int STEPN_W   = 16;

    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEW  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SELECTED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 2'd2;

    // 99.0 in single precision
    localparam logic [WORD_W-1:0] NO_DATA_BITS = 32'h42C6_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TSEL,
        ST_LAUNCH,
        ST_PROBE,
        ST_OEMIT
    } state_t;

    typedef enum logic [1:0] {
        SP_TIME,
        SP_OWNER,
        SP_NEXT
    } scan_purpose_t;

    typedef enum logic [1:0] {
        CLS_REC    = 2'd0,
        CLS_ZERO   = 2'd1,
        CLS_NODATA = 2'd2
    } sample_class_t;

    typedef struct packed {
        logic             never;
        logic [POS_W-1:0] last;
        logic [POS_W-1:0] first;
    } win_entry_t;

    typedef struct packed {
        logic          accept;
        logic          tbl_wr;
        logic          blk_clr;
        logic          step_adv;
        logic          scan_launch;
        logic          scan_next;
        logic          set_found;
        logic          set_none;
        logic          emit;
        scan_purpose_t purpose;
        sample_class_t cls;
    } cmd_t;

    typedef struct packed {
        logic time_due;
        logic launch_ok;
        logic hit;
        logic next_ok;
        logic out_free;
        logic sel_valid;
        logic sel_inside;
        logic sel_before;
        logic time_live;
        logic owner_emit;
    } status_t;

endpackage

### src/gauge_record_demultiplexer_unit.sv
// Top level of the gauge record demultiplexer.
//
// Input channel (in_valid/in_ready): one beat per item. kind selects a window
// load (station_index, first_step, final_step, never_recorded), a 32-bit data
// word, or a start of block. Output channel (out_valid/out_ready): one beat per
// sample of the selected station, with its step number and class.
// Configuration: cfg_we writes cfg_data into register cfg_index at the edge.
// Sequence: window loads and block starts are taken in the idle state. A time
// record advances the step, checks the selected station, then scans for the
// first active station; a station word scans from the expected station to
// confirm its owner, hands over its sample, then scans on for the next active one.
// The window table has one registered read port and the scan tests one station
// per cycle. A new item is taken only once the block is back in its idle state.
// Reset: config returns to station 0, one station, one step; the step counter
// clears and the next word is taken as a time record. The window table is not
// cleared and must be loaded before use.
// Stall: the result sits in an output register; the next item is taken, and
// only waits where it has a sample of its own to hand over.
module gauge_record_demultiplexer_unit #(
    parameter int MAX_STATIONS = 256,
    parameter int STEP_BITS    = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [grd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [grd_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [grd_pkg::KIND_W-1:0]    kind,
    input  logic [grd_pkg::IDX_W-1:0]     station_index,
    input  logic [grd_pkg::POS_W-1:0]     first_step,
    input  logic [grd_pkg::POS_W-1:0]     final_step,
    input  logic                          never_recorded,
    input  logic [grd_pkg::WORD_W-1:0]    word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [grd_pkg::WORD_W-1:0]    sample,
    output logic [grd_pkg::STEPN_W-1:0]   step_number,
    output logic [grd_pkg::CLASS_W-1:0]   sample_class
);
    import grd_pkg::*;

    cmd_t    cmd;
    status_t st;

    // sequencer: owns the item phases and the scan purpose
    grd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath: window table, counters, compares and the result register
    grd_dpath #(
        .MAX_STATIONS (MAX_STATIONS),
        .STEP_BITS    (STEP_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .station_index  (station_index),
        .first_step     (first_step),
        .final_step     (final_step),
        .never_recorded (never_recorded),
        .word           (word),
        .cmd            (cmd),
        .st             (st),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample         (sample),
        .step_number    (step_number),
        .sample_class   (sample_class)
    );

endmodule

### src/grd_win_mem.sv
// Station window table: one write port, one registered read port.
module grd_win_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  grd_pkg::win_entry_t  wdata,
    input  logic [AW-1:0]        raddr,
    output grd_pkg::win_entry_t  rdata
);
    import grd_pkg::*;

    win_entry_t mem [DEPTH];
    win_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/grd_ctrl.sv
// Sequencer for the demultiplexer: accept, selected-station check, station scan.
module grd_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [grd_pkg::KIND_W-1:0] kind,
    input  grd_pkg::status_t          st,
    output grd_pkg::cmd_t             cmd
);
    import grd_pkg::*;

    state_t        state_reg;
    state_t        state_next;
    scan_purpose_t purpose_reg;
    scan_purpose_t purpose_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            purpose_reg <= SP_TIME;
        end
        else
        begin
            state_reg   <= state_next;
            purpose_reg <= purpose_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        purpose_next = purpose_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.purpose  = purpose_reg;
        cmd.cls      = CLS_REC;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    case (kind)
                        KIND_LOAD:
                        begin
                            cmd.tbl_wr = 1'b1;
                        end
                        KIND_NEW:
                        begin
                            cmd.blk_clr = 1'b1;
                        end
                        KIND_DATA:
                        begin
                            if (st.time_due)
                            begin
                                cmd.step_adv = 1'b1;
                                state_next   = ST_TSEL;
                            end
                            else
                            begin
                                purpose_next = SP_OWNER;
                                state_next   = ST_LAUNCH;
                            end
                        end
                        default:
                        begin
                            cmd.accept = 1'b1;
                        end
                    endcase
                end
            end

            ST_TSEL:
            begin
                // time record: the selected station's off-window sample
                if (!st.sel_valid || st.sel_before)
                begin
                    cmd.cls = CLS_ZERO;
                end
                else
                begin
                    cmd.cls = CLS_NODATA;
                end
                if (!st.time_live || (st.sel_valid && st.sel_inside))
                begin
                    purpose_next = SP_TIME;
                    state_next   = ST_LAUNCH;
                end
                else if (st.out_free)
                begin
                    cmd.emit     = 1'b1;
                    purpose_next = SP_TIME;
                    state_next   = ST_LAUNCH;
                end
            end

            ST_LAUNCH:
            begin
                cmd.scan_launch = 1'b1;
                if (st.launch_ok)
                begin
                    state_next = ST_PROBE;
                end
                else
                begin
                    cmd.set_none = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            ST_PROBE:
            begin
                if (st.hit)
                begin
                    if (purpose_reg == SP_OWNER)
                    begin
                        state_next = ST_OEMIT;
                    end
                    else
                    begin
                        cmd.set_found = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else if (st.next_ok)
                begin
                    cmd.scan_next = 1'b1;
                end
                else
                begin
                    cmd.set_none = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            ST_OEMIT:
            begin
                cmd.cls = CLS_REC;
                if (!st.owner_emit || st.out_free)
                begin
                    cmd.emit     = st.owner_emit;
                    purpose_next = SP_NEXT;
                    state_next   = ST_LAUNCH;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/grd_dpath.sv
// Datapath: config, step and scan registers, window table, result register.
module grd_dpath #(
    parameter int MAX_STATIONS = 256,
    parameter int STEP_BITS    = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [grd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [grd_pkg::CFG_W-1:0]     cfg_data,
    input  logic [grd_pkg::IDX_W-1:0]     station_index,
    input  logic [grd_pkg::POS_W-1:0]     first_step,
    input  logic [grd_pkg::POS_W-1:0]     final_step,
    input  logic                          never_recorded,
    input  logic [grd_pkg::WORD_W-1:0]    word,
    input  grd_pkg::cmd_t                 cmd,
    output grd_pkg::status_t              st,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [grd_pkg::WORD_W-1:0]    sample,
    output logic [grd_pkg::STEPN_W-1:0]   step_number,
    output logic [grd_pkg::CLASS_W-1:0]   sample_class
);
    import grd_pkg::*;

    localparam int CNT_W = $clog2(MAX_STATIONS + 1);
    localparam int LW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int AW    = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
    localparam int CMP_W = (STEP_BITS > POS_W) ? STEP_BITS : POS_W;

    // configuration
    logic [IDX_W-1:0]   sel_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [POS_W-1:0]   total_reg;

    // block state
    logic [STEP_BITS-1:0] step_reg;
    logic [STEP_BITS-1:0] step_next;
    logic [LW-1:0]        scan_station_reg;
    logic [LW-1:0]        scan_station_next;
    logic                 expect_reg;
    logic                 expect_next;
    logic                 live_reg;
    logic                 live_next;
    logic [LW-1:0]        probe_reg;
    logic [LW-1:0]        probe_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    // payload
    logic [WORD_W-1:0]    word_reg;
    logic [WORD_W-1:0]    sample_reg;
    logic [STEPN_W-1:0]   step_out_reg;
    sample_class_t        class_reg;

    logic [LW-1:0]    live_cnt;
    logic [LW-1:0]    sel_ext;
    logic [LW-1:0]    idx_ext;
    logic [LW-1:0]    from_val;
    logic [LW-1:0]    probe_inc;
    logic [LW-1:0]    rd_val;
    logic [CMP_W-1:0] step_ext;
    logic [CMP_W-1:0] total_ext;
    logic [CMP_W-1:0] first_ext;
    logic [CMP_W-1:0] last_ext;
    logic             step_sat;
    logic             in_window;
    logic             load_ok;
    logic [WORD_W-1:0] sample_mux;
    win_entry_t       wdata;
    win_entry_t       rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= '0;
            count_reg <= COUNT_W'(1);
            total_reg <= POS_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SELECTED: sel_reg   <= cfg_data[IDX_W-1:0];
                CFG_COUNT:    count_reg <= cfg_data[COUNT_W-1:0];
                CFG_TOTAL:    total_reg <= cfg_data[POS_W-1:0];
                default:      ;
            endcase
        end
    end

    assign live_cnt  = (LW'(count_reg) > LW'(MAX_STATIONS)) ? LW'(MAX_STATIONS)
                                                            : LW'(count_reg);
    assign sel_ext   = LW'(sel_reg);
    assign idx_ext   = LW'(station_index);
    assign probe_inc = probe_reg + LW'(1);
    assign step_ext  = CMP_W'(step_reg);
    assign total_ext = CMP_W'(total_reg);
    assign first_ext = CMP_W'(rdata.first);
    assign last_ext  = CMP_W'(rdata.last);
    assign step_sat  = (step_reg == '1);
    assign in_window = (first_ext <= step_ext) && (step_ext <= last_ext);
    assign load_ok   = (idx_ext < LW'(MAX_STATIONS));

    always_comb
    begin
        case (cmd.purpose)
            SP_OWNER: from_val = scan_station_reg;
            SP_NEXT:  from_val = probe_inc;
            default:  from_val = '0;
        endcase
    end

    // read port follows the scan; otherwise it sits on the selected station
    assign rd_val = cmd.scan_launch ? from_val :
                    cmd.scan_next   ? probe_inc : sel_ext;

    assign wdata.never = never_recorded;
    assign wdata.last  = final_step;
    assign wdata.first = first_step;

    grd_win_mem #(
        .DEPTH (MAX_STATIONS),
        .AW    (AW)
    ) u_win_mem (
        .clk   (clk),
        .we    (cmd.tbl_wr && load_ok),
        .waddr (idx_ext[AW-1:0]),
        .wdata (wdata),
        .raddr (rd_val[AW-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        step_next         = step_reg;
        scan_station_next = scan_station_reg;
        expect_next       = expect_reg;
        live_next         = live_reg;
        probe_next        = probe_reg;
        out_valid_next    = out_valid_reg;

        if (cmd.blk_clr)
        begin
            step_next         = '0;
            scan_station_next = '0;
            expect_next       = 1'b1;
        end
        if (cmd.step_adv)
        begin
            step_next = step_sat ? step_reg : step_reg + STEP_BITS'(1);
            live_next = !step_sat && (step_ext < total_ext);
        end
        if (cmd.scan_launch || cmd.scan_next)
        begin
            probe_next = rd_val;
        end
        if (cmd.set_found)
        begin
            scan_station_next = probe_reg;
            expect_next       = 1'b0;
        end
        if (cmd.set_none)
        begin
            expect_next = 1'b1;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= '0;
            scan_station_reg <= '0;
            expect_reg       <= 1'b1;
            live_reg         <= 1'b0;
            probe_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            step_reg         <= step_next;
            scan_station_reg <= scan_station_next;
            expect_reg       <= expect_next;
            live_reg         <= live_next;
            probe_reg        <= probe_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_comb
    begin
        case (cmd.cls)
            CLS_REC:    sample_mux = word_reg;
            CLS_NODATA: sample_mux = NO_DATA_BITS;
            default:    sample_mux = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            word_reg <= word;
        end
        if (cmd.emit)
        begin
            sample_reg   <= sample_mux;
            step_out_reg <= step_ext[STEPN_W-1:0];
            class_reg    <= cmd.cls;
        end
    end

    assign st.time_due   = expect_reg;
    assign st.launch_ok  = (from_val < live_cnt);
    assign st.hit        = !rdata.never && in_window;
    assign st.next_ok    = (probe_inc < live_cnt);
    assign st.out_free   = !out_valid_reg || out_ready;
    assign st.sel_valid  = (sel_ext < live_cnt) && !rdata.never;
    assign st.sel_inside = in_window;
    assign st.sel_before = (step_ext < first_ext);
    assign st.time_live  = live_reg;
    assign st.owner_emit = (probe_reg == sel_ext) && (step_reg != '0)
                           && (step_ext <= total_ext);

    assign out_valid    = out_valid_reg;
    assign sample       = sample_reg;
    assign step_number  = step_out_reg;
    assign sample_class = class_reg;

`ifndef ASSERT_OFF
    // a pending result is never overwritten
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken beat");

    // the scan pointer never walks past the live stations
    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_next |=> (probe_reg < live_cnt))
        else $error("scan pointer beyond station count");

    // the step only moves on a time record
    a_step_on_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_adv |-> expect_reg)
        else $error("step advanced on a station word");

    // a found station is not marked never recorded
    a_found_active: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.set_found || cmd.emit && cmd.cls == CLS_REC) |-> !rdata.never)
        else $error("found station is marked never recorded");
`endif

endmodule

### dv/grd_tb_pkg.sv
`timescale 1ns / 1ps
// Sample predictor and scoreboard for the gauge record demultiplexer testbench.
package grd_tb_pkg;
    import grd_pkg::*;

    localparam int unsigned TABLE_DEPTH = 256;
    localparam int unsigned STEP_TOP    = (1 << STEPN_W) - 1;

    // the one kind code the block has no use for
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [WORD_W-1:0]  sample;
        logic [STEPN_W-1:0] step_no;
        sample_class_t      cls;
    } gauge_sample_t;

    class gauge_series_scoreboard;
        logic [POS_W-1:0] first_tab [TABLE_DEPTH];
        logic [POS_W-1:0] last_tab  [TABLE_DEPTH];
        logic             never_tab [TABLE_DEPTH];
        int unsigned      sel_station;
        int unsigned      station_cnt;
        int unsigned      series_len;
        int unsigned      step_no;
        int unsigned      scan_pos;
        bit               want_time;
        gauge_sample_t    pending_samples [$];
        int unsigned      errors;
        int unsigned      samples_seen;

        function new();
            sel_station  = 0;
            station_cnt  = 1;
            series_len   = 1;
            step_no      = 0;
            scan_pos     = 0;
            want_time    = 1'b1;
            errors       = 0;
            samples_seen = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_SELECTED: sel_station = val[IDX_W-1:0];
                CFG_COUNT:    station_cnt = val[COUNT_W-1:0];
                CFG_TOTAL:    series_len  = val[POS_W-1:0];
                default: ;
            endcase
        endfunction

        // counts above the table depth behave as the full table
        function int unsigned live_count();
            return (station_cnt > TABLE_DEPTH) ? TABLE_DEPTH : station_cnt;
        endfunction

        function bit on_air(int unsigned j, int unsigned s);
            if (j >= live_count() || never_tab[j])
                return 1'b0;
            return (first_tab[j] <= s) && (s <= last_tab[j]);
        endfunction

        function int unsigned next_on_air(int unsigned from, int unsigned s);
            for (int unsigned j = from; j < live_count(); j++)
                if (on_air(j, s))
                    return j;
            return live_count();
        endfunction

        function void expect_sample(logic [WORD_W-1:0] v, int unsigned s, sample_class_t c);
            gauge_sample_t e;
            e.sample  = v;
            e.step_no = STEPN_W'(s);
            e.cls     = c;
            pending_samples.push_back(e);
        endfunction

        function void note_beat(logic [KIND_W-1:0] k, logic [IDX_W-1:0] idx,
                                logic [POS_W-1:0] f, logic [POS_W-1:0] l, logic nv,
                                logic [WORD_W-1:0] w);
            int unsigned prev;
            int unsigned s;
            int unsigned owner;
            bit          live;
            bit          sel_ok;
            case (k)
                KIND_LOAD: begin
                    first_tab[idx] = f;
                    last_tab[idx]  = l;
                    never_tab[idx] = nv;
                end
                KIND_NEW: begin
                    step_no   = 0;
                    scan_pos  = 0;
                    want_time = 1'b1;
                end
                KIND_DATA: begin
                    if (want_time) begin
                        prev      = step_no;
                        live      = (prev < STEP_TOP) && (prev < series_len);
                        s         = (prev < STEP_TOP) ? prev + 1 : prev;
                        step_no   = s;
                        scan_pos  = next_on_air(0, s);
                        want_time = scan_pos >= live_count();
                        sel_ok    = (sel_station < live_count()) && !never_tab[sel_station];
                        if (live) begin
                            if (!sel_ok || s < first_tab[sel_station])
                                expect_sample('0, s, CLS_ZERO);
                            else if (s > last_tab[sel_station])
                                expect_sample(NO_DATA_BITS, s, CLS_NODATA);
                        end
                    end else begin
                        owner = next_on_air(scan_pos, step_no);
                        if (owner >= live_count()) begin
                            want_time = 1'b1;
                        end else begin
                            scan_pos  = next_on_air(owner + 1, step_no);
                            want_time = scan_pos >= live_count();
                            if (owner == sel_station && step_no >= 1 && step_no <= series_len)
                                expect_sample(w, step_no, CLS_REC);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_sample(logic [WORD_W-1:0] v, logic [STEPN_W-1:0] sn,
                                   logic [CLASS_W-1:0] c);
            gauge_sample_t e;
            samples_seen++;
            if (pending_samples.size() == 0) begin
                $error("unexpected sample beat: sample %h step %0d class %0d", v, sn, c);
                errors++;
                return;
            end
            e = pending_samples.pop_front();
            if (v !== e.sample) begin
                $error("sample mismatch: expected %h, got %h", e.sample, v);
                errors++;
            end
            if (sn !== e.step_no) begin
                $error("step_number mismatch: expected %0d, got %0d", e.step_no, sn);
                errors++;
            end
            if (c !== e.cls) begin
                $error("sample_class mismatch: expected %0d, got %0d", e.cls, c);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_samples.size();
        endfunction

        function void flush_leftovers();
            if (pending_samples.size() != 0) begin
                $error("%0d expected samples never arrived", pending_samples.size());
                errors += pending_samples.size();
                pending_samples.delete();
            end
        endfunction
    endclass

endpackage

### dv/tb_gauge_record_demultiplexer_unit.sv
`timescale 1ns / 1ps
// Testbench for the gauge record demultiplexer: random streams checked against a sample predictor.
module tb_gauge_record_demultiplexer_unit;
    import grd_pkg::*;
    import grd_tb_pkg::*;

    localparam int          CLK_PERIOD   = 4;
    localparam int unsigned RANDOM_ITEMS = 1650;
    localparam int unsigned CYCLE_LIMIT  = 4_000_000;
    localparam int unsigned DRAIN_LIMIT  = 20_000;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [CFG_W-1:0]     cfg_data       = '0;
    logic                 in_valid       = 1'b0;
    logic                 in_ready;
    logic [KIND_W-1:0]    kind           = KIND_LOAD;
    logic [IDX_W-1:0]     station_index  = '0;
    logic [POS_W-1:0]     first_step     = '0;
    logic [POS_W-1:0]     final_step     = '0;
    logic                 never_recorded = 1'b0;
    logic [WORD_W-1:0]    word           = '0;
    logic                 out_valid;
    logic                 out_ready      = 1'b0;
    logic [WORD_W-1:0]    sample;
    logic [STEPN_W-1:0]   step_number;
    logic [CLASS_W-1:0]   sample_class;

    gauge_series_scoreboard sb;

    int unsigned cycles      = 0;
    int unsigned beats_sent  = 0;
    int unsigned phases_run  = 0;
    bit          valid_held  = 1'b0;
    bit          gaps_on     = 1'b0;
    int          burst_left  = 0;
    int unsigned stall_mode  = 0;
    int unsigned stall_left  = 0;

    // Directed stream: the comments against each entry give the step it falls in
    // with stations 0 and 1 recording, 1 selected.
    logic [WORD_W-1:0] directed_words [0:14] = '{
        32'h3F80_0000,  // time record, step 1: before the selected window
        32'h1234_5678,  // station 0, not selected
        32'h4000_0000,  // time record, step 2
        32'hDEAD_BEEF,  // station 0
        32'h0000_0000,  // station 1: recorded all-zero word
        32'h4040_0000,  // time record, step 3
        32'hA5A5_A5A5,  // station 0
        32'hFFFF_FFFF,  // station 1: recorded all-ones word
        32'h4080_0000,  // time record, step 4 (station 1 only)
        32'h5A5A_5A5A,  // stray: window shrank under it mid-step
        32'h40A0_0000,  // time record, step 5: after the window, no-data
        32'h40C0_0000,  // time record, step 6: no-data, last counted step
        32'h40E0_0000,  // time record, step 7: past the series, silent
        32'h3F80_0000,  // new block, step 1: selected station never recorded
        32'h8000_0001   // station 0
    };

    always #(CLK_PERIOD / 2) clk = ~clk;

    gauge_record_demultiplexer_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .station_index  (station_index),
        .first_step     (first_step),
        .final_step     (final_step),
        .never_recorded (never_recorded),
        .word           (word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample         (sample),
        .step_number    (step_number),
        .sample_class   (sample_class)
    );

    // Receiver back-pressure: a new pattern whenever the current one runs out. Mode 0
    // never stalls, the others go from light random stalls to long blocked stretches.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 4);
            stall_left <= $urandom_range(50, 400);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            3:       out_ready <= ((stall_left % 7) < 3);
            default: out_ready <= ((stall_left % 32) >= 24);
        endcase
    end

    // Output beats are taken at the rising edge and checked against the oldest
    // expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_sample(sample, step_number, sample_class);
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_gauge_record_demultiplexer_unit: done, errors");
        $finish;
    end

    // All driving tasks start and end just after a falling edge. valid_held says
    // that in_valid is still up with the last accepted payload, so whoever goes
    // idle next has to drop it.
    task automatic send_item(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] idx,
                             input logic [POS_W-1:0] f, input logic [POS_W-1:0] l,
                             input logic nv, input logic [WORD_W-1:0] w);
        in_valid       <= 1'b1;
        kind           <= k;
        station_index  <= idx;
        first_step     <= f;
        final_step     <= l;
        never_recorded <= nv;
        word           <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_beat(k, idx, f, l, nv, w);
        if (k != KIND_UNUSED)
            beats_sent++;
        @(negedge clk);
        burst_left--;
        if (gaps_on && burst_left <= 0)
        begin
            in_valid   <= 1'b0;
            valid_held = 1'b0;
            // mostly short gaps, now and then a long one
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6))
                @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        else
        begin
            valid_held = 1'b1;
        end
    endtask

    // Unused fields carry random bits so that every input bit moves.
    task automatic send_data(input logic [WORD_W-1:0] w);
        send_item(KIND_DATA, IDX_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                  1'($urandom), w);
    endtask

    task automatic send_load(input int unsigned idx, input int unsigned f,
                             input int unsigned l, input logic nv);
        send_item(KIND_LOAD, IDX_W'(idx), POS_W'(f), POS_W'(l), nv, WORD_W'($urandom));
    endtask

    task automatic send_new();
        send_item(KIND_NEW, IDX_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                  1'($urandom), WORD_W'($urandom));
    endtask

    task automatic send_unused();
        send_item(KIND_UNUSED, IDX_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                  1'($urandom), WORD_W'($urandom));
    endtask

    // Window shapes: never recorded, empty (first after last), the full step range,
    // raw random bits, and ordinary windows around the steps the phase will reach.
    task automatic load_random_window(input int unsigned idx, input int unsigned horizon);
        int unsigned f;
        int unsigned l;
        logic        nv;
        nv = 1'b0;
        case ($urandom_range(0, 9))
            0:
            begin
                f  = $urandom_range(0, STEP_TOP);
                l  = $urandom_range(0, STEP_TOP);
                nv = 1'b1;
            end
            1:
            begin
                f = $urandom_range(2, horizon + 2);
                l = $urandom_range(0, f - 1);
            end
            2:
            begin
                f = 0;
                l = STEP_TOP;
            end
            3:
            begin
                f  = $urandom_range(0, STEP_TOP);
                l  = $urandom_range(0, STEP_TOP);
                nv = 1'($urandom);
            end
            default:
            begin
                f = $urandom_range(0, horizon);
                l = $urandom_range(f, horizon + 2);
            end
        endcase
        send_load(idx, f, l, nv);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        @(negedge clk);
        sb.set_register(idx, CFG_W'(val));
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input int unsigned sel, input int unsigned cnt,
                             input int unsigned tot);
        write_reg(CFG_SELECTED, sel);
        write_reg(CFG_COUNT, cnt);
        write_reg(CFG_TOTAL, tot);
    endtask

    // Quiesce: drop valid, wait for every expected sample, then give the block
    // time to finish a scan that produces nothing.
    task automatic wait_idle();
        int unsigned settle;
        int unsigned guard;
        settle = 2 * sb.live_count() + 24;
        guard  = 0;
        if (valid_held)
        begin
            in_valid   <= 1'b0;
            valid_held = 1'b0;
        end
        while (sb.pending() != 0 && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (settle) @(negedge clk);
        sb.flush_leftovers();
    endtask

    initial
    begin
        int unsigned n_steps;
        int unsigned cnt;
        int unsigned sel;
        int unsigned tot;
        int unsigned live_n;

        sb = new();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The table has no reset: fill every entry once so that no scan ever
        // touches an unwritten one.
        for (int j = 0; j < TABLE_DEPTH; j++)
            load_random_window(j, 8);

        // Directed stream. Station 0 records steps 1-3, station 1 (selected)
        // 2-4, station 2 is never recorded and station 3 has an empty window.
        // Mid-step 4 the selected window shrinks so the trailing word is a
        // stray; after a new block the selected station is marked never recorded.
        wait_idle();
        configure(1, 4, 6);
        send_load(0, 1, 3, 1'b0);
        send_load(1, 2, 4, 1'b0);
        send_load(2, 1, 6, 1'b1);
        send_load(3, 5, 2, 1'b0);
        send_new();
        for (int i = 0; i < 15; i++)
        begin
            send_data(directed_words[i]);
            if (i == 8)
                send_load(1, 2, 3, 1'b0);
            if (i == 9)
                send_unused();
            if (i == 12)
            begin
                send_new();
                send_load(1, 2, 4, 1'b1);
            end
        end

        // Random phases: new settings, fresh windows, then well-formed steps
        // (a time record and one word per recording station) with some noise:
        // ignored kinds, window reloads mid-step and block restarts.
        while (beats_sent < RANDOM_ITEMS)
        begin
            wait_idle();
            phases_run++;
            gaps_on    = ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 24);
            if (phases_run == 4 || phases_run == 13)
            begin
                // whole table in play, counts at and above the table depth
                cnt     = (phases_run == 4) ? TABLE_DEPTH : $urandom_range(TABLE_DEPTH + 1, 511);
                n_steps = 2;
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                cnt     = 0;
                n_steps = $urandom_range(3, 8);
            end
            else
            begin
                cnt     = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                      : $urandom_range(1, 8);
                n_steps = $urandom_range(4, 24);
            end
            live_n = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;

            if (phases_run == 4)
                sel = TABLE_DEPTH - 1;
            else
            begin
                case ($urandom_range(0, 9))
                    0:       sel = TABLE_DEPTH - 1;
                    1:       sel = $urandom_range(0, TABLE_DEPTH - 1);
                    default: sel = (live_n == 0) ? $urandom_range(0, TABLE_DEPTH - 1)
                                                 : $urandom_range(0, live_n - 1);
                endcase
            end

            case ($urandom_range(0, 7))
                0:       tot = 1;
                1:       tot = STEP_TOP;
                2:       tot = $urandom_range(1, n_steps);
                default: tot = n_steps;
            endcase

            configure(sel, cnt, tot);
            if (live_n <= 32)
            begin
                for (int j = 0; j < live_n; j++)
                    if ($urandom_range(0, 9) < 7)
                        load_random_window(j, n_steps);
            end
            send_new();

            for (int s = 0; s < n_steps; s++)
            begin
                send_data(WORD_W'($urandom));
                while (!sb.want_time)
                begin
                    case ($urandom_range(0, 49))
                        0:       send_unused();
                        1:       load_random_window($urandom_range(0, live_n - 1), n_steps);
                        2:       send_new();
                        default: send_data(WORD_W'($urandom));
                    endcase
                end
            end
        end

        wait_idle();

        $display("run covered %0d input beats: table fill, directed stream, %0d random phases",
                 beats_sent, phases_run);
        $display("%0d output samples checked, %0d mismatches", sb.samples_seen, sb.errors);
        if (sb.errors == 0)
            $display("tb_gauge_record_demultiplexer_unit: done, clean");
        else
            $display("tb_gauge_record_demultiplexer_unit: done, errors");
        $finish;
    end

endmodule
